// ===== hdl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, constants and helpers of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Bits per byte transfer and width of the bit counter
    localparam int BITS_PER_TRANSFER = 8;
    localparam int BIT_IDX_W         = 3;
    localparam int TIME_W            = 10;
    localparam int NUM_REGS          = 8;
    localparam int REG_IDX_W         = 3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_HI  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_ZERO_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    // Register reset values (microseconds)
    localparam logic [TIME_W-1:0] DEF_RESET_LOW     = 10'd500;
    localparam logic [TIME_W-1:0] DEF_PRESENCE_WAIT = 10'd120;
    localparam logic [TIME_W-1:0] DEF_RESET_TAIL    = 10'd380;
    localparam logic [TIME_W-1:0] DEF_SHORT_LOW     = 10'd2;
    localparam logic [TIME_W-1:0] DEF_WRITE_ONE_HI  = 10'd58;
    localparam logic [TIME_W-1:0] DEF_WRITE_ZERO_LO = 10'd65;
    localparam logic [TIME_W-1:0] DEF_READ_SAMPLE   = 10'd13;
    localparam logic [TIME_W-1:0] DEF_READ_TAIL     = 10'd45;

    // Command mode codes on the input
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Classified command of one tick
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_RESET,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    // Bus sequencer phase
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_W1_LOW,
        PH_W1_HIGH,
        PH_W0_LOW,
        PH_W0_REC,
        PH_R_LOW,
        PH_R_WAIT,
        PH_R_TAIL
    } phase_t;

    // One queued tick
    typedef struct packed {
        logic       line;
        cmd_t       cmd;
        logic [7:0] wdata;
    } tick_t;

    // Slot timings
    typedef struct packed {
        logic [TIME_W-1:0] reset_low;
        logic [TIME_W-1:0] presence_wait;
        logic [TIME_W-1:0] reset_tail;
        logic [TIME_W-1:0] short_low;
        logic [TIME_W-1:0] write_one_high;
        logic [TIME_W-1:0] write_zero_low;
        logic [TIME_W-1:0] read_sample;
        logic [TIME_W-1:0] read_tail;
    } timing_t;

    // A zero timing counts as one tick
    function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

// ===== hdl/owm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Slot timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output timing_t              timing
);

    timing_t timing_reg;

    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    // Register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low      <= DEF_RESET_LOW;
            timing_reg.presence_wait  <= DEF_PRESENCE_WAIT;
            timing_reg.reset_tail     <= DEF_RESET_TAIL;
            timing_reg.short_low      <= DEF_SHORT_LOW;
            timing_reg.write_one_high <= DEF_WRITE_ONE_HI;
            timing_reg.write_zero_low <= DEF_WRITE_ZERO_LO;
            timing_reg.read_sample    <= DEF_READ_SAMPLE;
            timing_reg.read_tail      <= DEF_READ_TAIL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RESET_LOW:     timing_reg.reset_low      <= cfg_data;
                REG_PRESENCE_WAIT: timing_reg.presence_wait  <= cfg_data;
                REG_RESET_TAIL:    timing_reg.reset_tail     <= cfg_data;
                REG_SHORT_LOW:     timing_reg.short_low      <= cfg_data;
                REG_WRITE_ONE_HI:  timing_reg.write_one_high <= cfg_data;
                REG_WRITE_ZERO_LO: timing_reg.write_zero_low <= cfg_data;
                REG_READ_SAMPLE:   timing_reg.read_sample    <= cfg_data;
                REG_READ_TAIL:     timing_reg.read_tail      <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

// ===== hdl/owm_front.sv =====
// ----------------------------------------------------------------------------
// owm_front
// Takes tick words and decodes the command request into a queue word.
// ----------------------------------------------------------------------------
module owm_front
    import owm_pkg::*;
(
    input  logic       line_level,
    input  logic       start_req,
    input  logic [1:0] mode,
    input  logic [7:0] write_data,
    output tick_t      tick
);

    // Command decode; an unknown mode is no request
    always_comb
    begin
        tick.line  = line_level;
        tick.wdata = write_data;
        tick.cmd   = CMD_NONE;
        if (start_req)
        begin
            case (mode)
                MODE_RESET: tick.cmd = CMD_RESET;
                MODE_WRITE: tick.cmd = CMD_WRITE;
                MODE_READ:  tick.cmd = CMD_READ;
                default:    tick.cmd = CMD_NONE;
            endcase
        end
    end

endmodule

// ===== hdl/owm_queue.sv =====
// ----------------------------------------------------------------------------
// owm_queue
// Two-entry queue of decoded tick words between front and sequencer.
// ----------------------------------------------------------------------------
module owm_queue
    import owm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  tick_t push_word,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output tick_t pop_word
);

    tick_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_word = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/owm_engine.sv =====
// ----------------------------------------------------------------------------
// owm_engine
// Slot sequencer: runs one tick per queue word and registers the result word.
// ----------------------------------------------------------------------------
module owm_engine
    import owm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  timing_t    timing,
    input  logic       q_empty,
    input  tick_t      q_word,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       drive_low,
    output logic       busy_res,
    output logic       done_res,
    output logic       device_present,
    output logic [7:0] read_data
);

    localparam logic [BIT_IDX_W:0] BIT_COUNT = (BIT_IDX_W+1)'(BITS_PER_TRANSFER);

    // Sequencer state
    phase_t                phase_reg,    phase_next;
    logic [TIME_W-1:0]     time_left_reg, time_left_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg,  bit_idx_next;
    logic [7:0]            shift_reg,    shift_next;
    logic                  presence_reg, presence_next;
    logic [7:0]            rbyte_reg,    rbyte_next;
    logic                  is_write_reg, is_write_next;

    // Result word
    logic                  out_valid_reg;
    logic                  drive_reg,    drive_next;
    logic                  busy_reg;
    logic                  done_reg,     done_next;

    logic                  bit_end;
    logic                  finish;
    logic [BIT_IDX_W:0]    bit_inc;

    assign q_pop          = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign drive_low      = drive_reg;
    assign busy_res       = busy_reg;
    assign done_res       = done_reg;
    assign device_present = presence_reg;
    assign read_data      = rbyte_reg;
    assign bit_inc        = {1'b0, bit_idx_reg} + {{BIT_IDX_W{1'b0}}, 1'b1};

    // Next state for one tick
    always_comb
    begin
        phase_next     = phase_reg;
        time_left_next = time_left_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        rbyte_next     = rbyte_reg;
        is_write_next  = is_write_reg;
        drive_next     = 1'b0;
        done_next      = 1'b0;
        bit_end        = 1'b0;
        finish         = 1'b0;

        // Command start: this tick is already the first of the first interval
        if (phase_reg == PH_IDLE)
        begin
            case (q_word.cmd)
                CMD_RESET:
                begin
                    bit_idx_next   = '0;
                    presence_next  = 1'b0;
                    phase_next     = PH_RST_LOW;
                    time_left_next = at_least_one(timing.reset_low);
                end
                CMD_WRITE:
                begin
                    bit_idx_next  = '0;
                    is_write_next = 1'b1;
                    shift_next    = q_word.wdata;
                    if (q_word.wdata[0])
                    begin
                        phase_next     = PH_W1_LOW;
                        time_left_next = at_least_one(timing.short_low);
                    end
                    else
                    begin
                        phase_next     = PH_W0_LOW;
                        time_left_next = at_least_one(timing.write_zero_low);
                    end
                end
                CMD_READ:
                begin
                    bit_idx_next   = '0;
                    is_write_next  = 1'b0;
                    rbyte_next     = '0;
                    phase_next     = PH_R_LOW;
                    time_left_next = at_least_one(timing.short_low);
                end
                default: ;
            endcase
        end

        // Interval countdown and phase advance
        if (phase_next != PH_IDLE)
        begin
            drive_next = (phase_next inside {PH_RST_LOW, PH_W1_LOW, PH_W0_LOW, PH_R_LOW});
            time_left_next = time_left_next - {{(TIME_W-1){1'b0}}, 1'b1};
            if (time_left_next == '0)
            begin
                case (phase_next)
                    PH_RST_LOW:
                    begin
                        phase_next     = PH_RST_WAIT;
                        time_left_next = at_least_one(timing.presence_wait);
                    end
                    PH_RST_WAIT:
                    begin
                        // Line low at the sample point means a device answered
                        presence_next = ~q_word.line;
                        if (timing.reset_tail == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next     = PH_RST_TAIL;
                            time_left_next = timing.reset_tail;
                        end
                    end
                    PH_W1_LOW:
                    begin
                        phase_next     = PH_W1_HIGH;
                        time_left_next = at_least_one(timing.write_one_high);
                    end
                    PH_W0_LOW:
                    begin
                        // One released tick for recovery
                        phase_next     = PH_W0_REC;
                        time_left_next = {{(TIME_W-1){1'b0}}, 1'b1};
                    end
                    PH_R_LOW:
                    begin
                        phase_next     = PH_R_WAIT;
                        time_left_next = at_least_one(timing.read_sample);
                    end
                    PH_R_WAIT:
                    begin
                        if (q_word.line)
                        begin
                            rbyte_next[bit_idx_reg] = 1'b1;
                        end
                        if (timing.read_tail == '0)
                        begin
                            bit_end = 1'b1;
                        end
                        else
                        begin
                            phase_next     = PH_R_TAIL;
                            time_left_next = timing.read_tail;
                        end
                    end
                    PH_W1_HIGH, PH_W0_REC, PH_R_TAIL:
                    begin
                        bit_end = 1'b1;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                // Next bit slot or end of transfer
                if (bit_end)
                begin
                    if (bit_inc >= BIT_COUNT)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        bit_idx_next = bit_inc[BIT_IDX_W-1:0];
                        shift_next   = {1'b0, shift_reg[7:1]};
                        if (!is_write_reg)
                        begin
                            phase_next     = PH_R_LOW;
                            time_left_next = at_least_one(timing.short_low);
                        end
                        else if (shift_reg[1])
                        begin
                            phase_next     = PH_W1_LOW;
                            time_left_next = at_least_one(timing.short_low);
                        end
                        else
                        begin
                            phase_next     = PH_W0_LOW;
                            time_left_next = at_least_one(timing.write_zero_low);
                        end
                    end
                end

                if (finish)
                begin
                    phase_next     = PH_IDLE;
                    time_left_next = '0;
                    done_next      = 1'b1;
                end
            end
        end
    end

    // Control state, advanced once per popped tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            time_left_reg <= '0;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            rbyte_reg     <= '0;
            is_write_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else if (q_pop)
        begin
            phase_reg     <= phase_next;
            time_left_reg <= time_left_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            rbyte_reg     <= rbyte_next;
            is_write_reg  <= is_write_next;
            out_valid_reg <= 1'b1;
            drive_reg     <= drive_next;
            busy_reg      <= (phase_next != PH_IDLE);
            done_reg      <= done_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== hdl/one_wire_bus_master_top.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// 1-Wire bus master driven by a one-microsecond tick stream.
// ----------------------------------------------------------------------------
//  channel | handshake              | word
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_ready    | line_level, start_req, mode, write_data
//  out     | out_valid / out_ready  | drive_low, busy_res, done_res,
//          |                        | device_present, read_data
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One tick word in, one result word out. The front decode is combinational and
// the tick is registered in the queue; the sequencer retires one queued tick a
// cycle while the output is not stalled, so one word per cycle is sustained.
// The two-entry queue and the output register let either side stall alone;
// in_ready drops only when the queue is full. Reset loads the default slot
// timings and clears the sequencer; cfg_ready is always high.
module one_wire_bus_master_top
    import owm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 line_level,
    input  logic                 start_req,
    input  logic [1:0]           mode,
    input  logic [7:0]           write_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 drive_low,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 device_present,
    output logic [7:0]           read_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    timing_t timing;
    tick_t   front_word;
    tick_t   q_word;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    assign in_ready = !q_full;

    // Slot timing registers
    owm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    // Command decode
    owm_front u_front (
        .line_level (line_level),
        .start_req  (start_req),
        .mode       (mode),
        .write_data (write_data),
        .tick       (front_word)
    );

    // Tick queue
    owm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_word (front_word),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_word  (q_word)
    );

    // Slot sequencer
    owm_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .timing         (timing),
        .q_empty        (q_empty),
        .q_word         (q_word),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .device_present (device_present),
        .read_data      (read_data)
    );

endmodule

// ===== hdl/owm_checker.sv =====
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks of the bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owm_checker
    import owm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic drive_low,
    input logic busy_res,
    input logic done_res
);

    // No result word while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result word valid during reset");

    // A finishing tick is never also busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done and busy on the same tick");

    // The line is only pulled low inside a running command
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_low |-> busy_res && !done_res)
        else $error("line driven low outside a command");

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(done_res) && $stable(busy_res))
        else $error("stalled result word dropped or changed");

endmodule

bind one_wire_bus_master_top owm_checker u_owm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive_low (drive_low),
    .busy_res  (busy_res),
    .done_res  (done_res)
);

// ===== test/one_wire_bus_master_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_checker
// Watches the tick, result and register channels of the 1-Wire master. Keeps
// its own copy of the slot timings and of the bus sequencer, predicts one
// result word per accepted tick word and compares results in order.
// ----------------------------------------------------------------------------
module one_wire_bus_master_checker
    import owm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 line_level,
    input  logic                 start_req,
    input  logic [1:0]           mode,
    input  logic [7:0]           write_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 drive_low,
    input  logic                 busy_res,
    input  logic                 done_res,
    input  logic                 device_present,
    input  logic [7:0]           read_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output int                   pending,
    output logic                 seq_busy,
    output int                   fail_count
);

    // Released recovery after a write-zero low pulse
    localparam logic [TIME_W-1:0] W0_RECOVERY = 10'd1;

    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic       present;
        logic [7:0] rdata;
    } bus_word_t;

    // Shadow timings and sequencer state
    logic [TIME_W-1:0]    tmr [NUM_REGS];
    phase_t               ph;
    logic [TIME_W-1:0]    remain;
    logic [BIT_IDX_W-1:0] bit_no;
    logic [7:0]           tx_byte;
    logic                 present_q;
    logic [7:0]           rx_byte;
    logic [1:0]           cmd_mode;
    logic                 done_q;

    bus_word_t            words_due [$];
    int                   errors;

    // Enter an interval; a zero length still lasts one tick
    task automatic enter_interval(input phase_t p, input logic [TIME_W-1:0] t);
        ph     = p;
        remain = (t == '0) ? W0_RECOVERY : t;
    endtask

    task automatic finish_cmd();
        ph     = PH_IDLE;
        remain = '0;
        done_q = 1'b1;
    endtask

    // First interval of the slot for the current bit
    task automatic start_slot();
        if (cmd_mode == MODE_WRITE)
        begin
            if (tx_byte[0])
                enter_interval(PH_W1_LOW, tmr[REG_SHORT_LOW]);
            else
                enter_interval(PH_W0_LOW, tmr[REG_WRITE_ZERO_LO]);
        end
        else
        begin
            enter_interval(PH_R_LOW, tmr[REG_SHORT_LOW]);
        end
    endtask

    task automatic end_slot();
        if (int'(bit_no) + 1 >= BITS_PER_TRANSFER)
        begin
            finish_cmd();
        end
        else
        begin
            bit_no  = bit_no + 1'b1;
            tx_byte = tx_byte >> 1;
            start_slot();
        end
    endtask

    // One microsecond tick through the sequencer
    task automatic bus_tick(input logic line, input logic start, input logic [1:0] md,
                            input logic [7:0] wd, output bus_word_t w);
        logic drv;
        drv    = 1'b0;
        done_q = 1'b0;
        if (ph == PH_IDLE && start &&
            (md == MODE_RESET || md == MODE_WRITE || md == MODE_READ))
        begin
            cmd_mode = md;
            bit_no   = '0;
            if (md == MODE_RESET)
            begin
                present_q = 1'b0;
                enter_interval(PH_RST_LOW, tmr[REG_RESET_LOW]);
            end
            else
            begin
                if (md == MODE_WRITE)
                    tx_byte = wd;
                else
                    rx_byte = '0;
                start_slot();
            end
        end
        if (ph != PH_IDLE)
        begin
            drv = (ph == PH_RST_LOW || ph == PH_W1_LOW || ph == PH_W0_LOW ||
                   ph == PH_R_LOW);
            remain = remain - 1'b1;
            if (remain == '0)
            begin
                case (ph)
                    PH_RST_LOW:  enter_interval(PH_RST_WAIT, tmr[REG_PRESENCE_WAIT]);
                    PH_RST_WAIT:
                    begin
                        // line pulled low by a device means presence
                        present_q = !line;
                        if (tmr[REG_RESET_TAIL] == '0)
                            finish_cmd();
                        else
                            enter_interval(PH_RST_TAIL, tmr[REG_RESET_TAIL]);
                    end
                    PH_RST_TAIL: finish_cmd();
                    PH_W1_LOW:   enter_interval(PH_W1_HIGH, tmr[REG_WRITE_ONE_HI]);
                    PH_W0_LOW:   enter_interval(PH_W0_REC, W0_RECOVERY);
                    PH_W1_HIGH, PH_W0_REC, PH_R_TAIL: end_slot();
                    PH_R_LOW:    enter_interval(PH_R_WAIT, tmr[REG_READ_SAMPLE]);
                    PH_R_WAIT:
                    begin
                        if (line)
                            rx_byte[bit_no] = 1'b1;
                        if (tmr[REG_READ_TAIL] == '0)
                            end_slot();
                        else
                            enter_interval(PH_R_TAIL, tmr[REG_READ_TAIL]);
                    end
                    default:     finish_cmd();
                endcase
            end
        end
        w = '{drv, (ph != PH_IDLE), done_q, present_q, rx_byte};
    endtask

    task automatic field_check(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Channel monitor: register writes, tick words in, result words out
    always @(posedge clk or negedge rst_n)
    begin
        bus_word_t w;
        if (!rst_n)
        begin
            tmr[REG_RESET_LOW]     = DEF_RESET_LOW;
            tmr[REG_PRESENCE_WAIT] = DEF_PRESENCE_WAIT;
            tmr[REG_RESET_TAIL]    = DEF_RESET_TAIL;
            tmr[REG_SHORT_LOW]     = DEF_SHORT_LOW;
            tmr[REG_WRITE_ONE_HI]  = DEF_WRITE_ONE_HI;
            tmr[REG_WRITE_ZERO_LO] = DEF_WRITE_ZERO_LO;
            tmr[REG_READ_SAMPLE]   = DEF_READ_SAMPLE;
            tmr[REG_READ_TAIL]     = DEF_READ_TAIL;
            ph         = PH_IDLE;
            remain     = '0;
            bit_no     = '0;
            tx_byte    = '0;
            present_q  = 1'b0;
            rx_byte    = '0;
            cmd_mode   = MODE_RESET;
            done_q     = 1'b0;
            errors     = 0;
            words_due.delete();
            pending    <= 0;
            seq_busy   <= 1'b0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tmr[cfg_index] = cfg_data;
            if (in_valid && in_ready)
            begin
                bus_tick(line_level, start_req, mode, write_data, w);
                words_due.push_back(w);
            end
            if (out_valid && out_ready)
            begin
                if (words_due.size() == 0)
                begin
                    $error("result word with no tick word waiting");
                    errors++;
                end
                else
                begin
                    w = words_due.pop_front();
                    field_check("drive_low", 8'(w.drive), 8'(drive_low));
                    field_check("busy_res", 8'(w.busy), 8'(busy_res));
                    field_check("done_res", 8'(w.done), 8'(done_res));
                    field_check("device_present", 8'(w.present), 8'(device_present));
                    field_check("read_data", w.rdata, read_data);
                end
            end
            pending    <= words_due.size();
            seq_busy   <= (ph != PH_IDLE);
            fail_count <= errors;
        end
    end

endmodule

// ===== test/one_wire_bus_master_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_top_tb
// Drives tick words and register writes into the 1-Wire master under several
// timing sets and idling patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top_tb;
    import owm_pkg::*;

    // Mode code with no command behind it
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Line level source for tick words
    localparam int LINE_LOW    = 0;
    localparam int LINE_HIGH   = 1;
    localparam int LINE_RANDOM = 2;

    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_TICKS  = 120;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 line_level;
    logic                 start_req;
    logic [1:0]           mode;
    logic [7:0]           write_data;
    logic                 out_valid;
    logic                 out_ready;
    logic                 drive_low;
    logic                 busy_res;
    logic                 done_res;
    logic                 device_present;
    logic [7:0]           read_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;

    int                   pending;
    logic                 seq_busy;
    int                   fail_count;

    int                   send_idle_pct;
    int                   stall_pct;
    int                   line_pick;
    int                   quiet;

    one_wire_bus_master_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .line_level     (line_level),
        .start_req      (start_req),
        .mode           (mode),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .device_present (device_present),
        .read_data      (read_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    one_wire_bus_master_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .line_level     (line_level),
        .start_req      (start_req),
        .mode           (mode),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .device_present (device_present),
        .read_data      (read_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .seq_busy       (seq_busy),
        .fail_count     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no word moving on any channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet <= 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("one_wire_bus_master_top_tb: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [1:0] draw_mode();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return MODE_UNUSED;
        else if (r <= 3)
            return MODE_RESET;
        else if (r <= 6)
            return MODE_WRITE;
        else
            return MODE_READ;
    endfunction

    function automatic timing_t draw_timing(input int unsigned lo, input int unsigned hi);
        timing_t t;
        t.reset_low      = TIME_W'($urandom_range(hi, lo));
        t.presence_wait  = TIME_W'($urandom_range(hi, lo));
        t.reset_tail     = TIME_W'($urandom_range(hi, lo));
        t.short_low      = TIME_W'($urandom_range(hi, lo));
        t.write_one_high = TIME_W'($urandom_range(hi, lo));
        t.write_zero_low = TIME_W'($urandom_range(hi, lo));
        t.read_sample    = TIME_W'($urandom_range(hi, lo));
        t.read_tail      = TIME_W'($urandom_range(hi, lo));
        return t;
    endfunction

    // One tick word, after a random sender gap
    task automatic push_tick(input logic start, input logic [1:0] md, input logic [7:0] wd);
        logic lvl;
        if (line_pick == LINE_RANDOM)
            lvl = 1'($urandom_range(1));
        else
            lvl = (line_pick == LINE_HIGH);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        line_level <= lvl;
        start_req  <= start;
        mode       <= md;
        write_data <= wd;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Plain ticks until the sequencer is idle again
    task automatic settle();
        do
            push_tick(1'b0, draw_mode(), 8'($urandom_range(255)));
        while (seq_busy);
    endtask

    // A command and its ticks; noisy ticks request starts while busy
    task automatic run_command(input logic [1:0] md, input logic [7:0] wd, input logic noisy);
        push_tick(1'b1, md, wd);
        do
            push_tick(noisy && $urandom_range(1), draw_mode(), 8'($urandom_range(255)));
        while (seq_busy);
        settle();
    endtask

    // Stop sending and wait for every result word
    task automatic quiesce();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_timing(input timing_t t);
        reg_write(REG_RESET_LOW, t.reset_low);
        reg_write(REG_PRESENCE_WAIT, t.presence_wait);
        reg_write(REG_RESET_TAIL, t.reset_tail);
        reg_write(REG_SHORT_LOW, t.short_low);
        reg_write(REG_WRITE_ONE_HI, t.write_one_high);
        reg_write(REG_WRITE_ZERO_LO, t.write_zero_low);
        reg_write(REG_READ_SAMPLE, t.read_sample);
        reg_write(REG_READ_TAIL, t.read_tail);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        line_level    = 1'b1;
        start_req     = 1'b0;
        mode          = MODE_RESET;
        write_data    = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_RESET_LOW;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        line_pick     = LINE_RANDOM;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default timings: one write byte with both slot kinds
        run_command(MODE_WRITE, 8'hA5, 1'b0);
        quiesce();

        // All timings zero: minimum intervals and skipped tails
        write_timing(draw_timing(0, 0));
        push_tick(1'b1, MODE_UNUSED, 8'hFF);
        line_pick = LINE_LOW;
        run_command(MODE_RESET, 8'h00, 1'b0);
        line_pick = LINE_HIGH;
        run_command(MODE_RESET, 8'hFF, 1'b0);
        run_command(MODE_WRITE, 8'h00, 1'b0);
        run_command(MODE_WRITE, 8'hFF, 1'b0);
        run_command(MODE_READ, 8'h00, 1'b0);
        line_pick = LINE_LOW;
        run_command(MODE_READ, 8'hFF, 1'b0);
        line_pick = LINE_RANDOM;
        run_command(MODE_READ, 8'h5A, 1'b1);
        run_command(MODE_WRITE, 8'($urandom_range(255)), 1'b1);
        quiesce();

        // Random ticks under small random timings and each idling pattern
        for (int phase_no = 0; phase_no < 4; phase_no++)
        begin
            write_timing(draw_timing(0, 4));
            case (phase_no)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 87; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 87; end
                default: begin send_idle_pct = 33; stall_pct <= 33; end
            endcase
            for (int n = 0; n < RAND_TICKS; n++)
            begin
                // hold off mid-phase until the block has drained
                if (n == RAND_TICKS / 2)
                    quiesce();
                push_tick($urandom_range(99) < 40, draw_mode(), 8'($urandom_range(255)));
            end
            settle();
            quiesce();
        end

        send_idle_pct = 0;
        stall_pct    <= 0;
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("one_wire_bus_master_top_tb: PASS");
        else
            $display("one_wire_bus_master_top_tb: FAIL");
        $finish;
    end

endmodule
